// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Implication or plain property, checked outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== design/i2cmbe_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Types, codes and timing helpers shared by the bit engine files.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int unsigned TICK_W = 10;

  localparam logic [7:0] TPU_RESET         = 8'd8;
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

  // Shift amounts turning microseconds into ticks
  localparam logic [1:0] SH_1US = 2'd0;
  localparam logic [1:0] SH_2US = 2'd1;
  localparam logic [1:0] SH_4US = 2'd2;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_WRITE   = 3'd3,
    OP_READ    = 3'd4,
    OP_ACK     = 3'd5,
    OP_NACK    = 3'd6,
    OP_WAITACK = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    PH_0 = 3'b001,
    PH_1 = 3'b010,
    PH_2 = 3'b100
  } phase_e;

  typedef enum logic {
    REG_TICKS_PER_US = 1'b0,
    REG_ACK_TIMEOUT  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] ticks_per_us;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
    logic       rejected;
  } res_t;

  typedef struct packed {
    op_e               command_held;
    phase_e            phase;
    logic [3:0]        bit_index;
    logic [7:0]        shift_reg;
    logic [TICK_W-1:0] tick_left;
    logic [7:0]        ack_ticks;
    logic              scl_level;
    logic              sda_level;
    logic              sda_dir;
    logic [7:0]        rx_reg;
    logic              ack_flag;
  } state_t;

  // Ticks in a phase of (1 << sh) microseconds; never less than one
  function automatic logic [TICK_W-1:0] phase_ticks(logic [7:0] tpu, logic [1:0] sh);
    logic [TICK_W-1:0] d;
    d = {{(TICK_W-8){1'b0}}, tpu} << sh;
    if (d == '0) begin
      d = {{(TICK_W-1){1'b0}}, 1'b1};
    end
    return d;
  endfunction

endpackage

// ===== design/i2cmbe_if.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine channels
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface i2cmbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, operation, tx_byte, sda_in, input ready);
  modport sink   (input valid, operation, tx_byte, sda_in, output ready);
endinterface

interface i2cmbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_missing;
  logic       rejected;

  modport source (output valid, scl, sda_out, sda_drive, busy_res, done_res, rx_byte,
                  ack_missing, rejected, input ready);
  modport sink   (input valid, scl, sda_out, sda_drive, busy_res, done_res, rx_byte,
                  ack_missing, rejected, output ready);
endinterface

interface i2cmbe_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/i2cmbe_cfg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine register file
// Holds ticks per microsecond and the ack timeout.
// ----------------------------------------------------------------------------
module i2cmbe_cfg import i2cmbe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2cmbe_cfg_if.sink   cfg_i,
  output cfg_t         cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_us <= TPU_RESET;
      cfg_q.ack_timeout  <= ACK_TIMEOUT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_TICKS_PER_US: cfg_q.ticks_per_us <= cfg_i.data;
        REG_ACK_TIMEOUT:  cfg_q.ack_timeout  <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/i2cmbe_in_stage.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine input register
// Captures one input word and holds it until the engine steps on it.
// ----------------------------------------------------------------------------
module i2cmbe_in_stage import i2cmbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cmbe_in_if.sink   in_i,
  input  logic        take_i,
  output logic        valid_o,
  output in_item_t    item_o
);

  logic     valid_q;
  in_item_t item_q;

  assign in_i.ready = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= '{operation: in_i.operation, tx_byte: in_i.tx_byte, sda_in: in_i.sda_in};
    end
  end

endmodule

// ===== design/i2cmbe_core.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine core
// Bus state and the single-step update for one tick or command word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cmbe_core import i2cmbe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  in_item_t item_i,
  input  logic     step_i,
  output res_t     res_o
);

  state_t     st_q, st_d;
  logic       done, rej;
  op_e        op;
  logic       busy;
  logic [3:0] bit_nxt;
  logic [7:0] ack_nxt;
  logic [7:0] shift_in;

  assign op       = op_e'(item_i.operation);
  assign busy     = (st_q.command_held != OP_TICK);
  assign bit_nxt  = st_q.bit_index + 4'd1;
  assign ack_nxt  = st_q.ack_ticks + 8'd1;
  assign shift_in = {st_q.shift_reg[6:0], item_i.sda_in};

  always_comb begin
    st_d = st_q;
    done = 1'b0;
    rej  = 1'b0;
    if (op == OP_TICK) begin
      if (busy) begin
        if (st_q.command_held == OP_WAITACK && st_q.phase == PH_2) begin
          if (!item_i.sda_in) begin
            st_d.scl_level = 1'b0;
            st_d.ack_flag  = 1'b0;
            done           = 1'b1;
          end else begin
            st_d.ack_ticks = ack_nxt;
            if (ack_nxt >= cfg_i.ack_timeout) begin
              st_d.scl_level = 1'b0;
              st_d.ack_flag  = 1'b1;
              done           = 1'b1;
            end
          end
        end else if (st_q.tick_left > {{(TICK_W-1){1'b0}}, 1'b1}) begin
          st_d.tick_left = st_q.tick_left - {{(TICK_W-1){1'b0}}, 1'b1};
        end else begin
          case (st_q.command_held)
            OP_START: begin
              if (st_q.phase == PH_0) begin
                st_d.sda_level = 1'b0;
                st_d.phase     = PH_1;
                st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_4US);
              end else begin
                st_d.scl_level = 1'b0;
                done           = 1'b1;
              end
            end
            OP_STOP: begin
              if (st_q.phase == PH_0) begin
                st_d.scl_level = 1'b1;
                st_d.sda_level = 1'b1;
                st_d.phase     = PH_1;
                st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_4US);
              end else begin
                done = 1'b1;
              end
            end
            OP_WRITE: begin
              if (st_q.phase == PH_0) begin
                st_d.scl_level = 1'b1;
                st_d.phase     = PH_1;
                st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_2US);
              end else if (st_q.phase == PH_1) begin
                st_d.scl_level = 1'b0;
                st_d.phase     = PH_2;
                st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_2US);
              end else begin
                st_d.bit_index = bit_nxt;
                if (bit_nxt >= BITS_PER_BYTE) begin
                  done = 1'b1;
                end else begin
                  st_d.sda_level = st_q.shift_reg[7];
                  st_d.shift_reg = {st_q.shift_reg[6:0], 1'b0};
                  st_d.phase     = PH_0;
                  st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_2US);
                end
              end
            end
            OP_READ: begin
              if (st_q.phase == PH_0) begin
                st_d.scl_level = 1'b1;
                st_d.phase     = PH_1;
                st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_2US);
              end else begin
                st_d.shift_reg = shift_in;
                st_d.bit_index = bit_nxt;
                if (bit_nxt >= BITS_PER_BYTE) begin
                  st_d.rx_reg = shift_in;
                  done        = 1'b1;
                end else begin
                  st_d.scl_level = 1'b0;
                  st_d.phase     = PH_0;
                  st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_2US);
                end
              end
            end
            OP_ACK, OP_NACK: begin
              if (st_q.phase == PH_0) begin
                st_d.scl_level = 1'b1;
                st_d.phase     = PH_1;
                st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_2US);
              end else begin
                st_d.scl_level = 1'b0;
                done           = 1'b1;
              end
            end
            OP_WAITACK: begin
              if (st_q.phase == PH_0) begin
                st_d.scl_level = 1'b1;
                st_d.phase     = PH_1;
                st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_1US);
              end else begin
                st_d.phase     = PH_2;
                st_d.tick_left = '0;
              end
            end
            default: done = 1'b1;
          endcase
        end
        // Finish: drop back to idle
        if (done) begin
          st_d.command_held = OP_TICK;
          st_d.phase        = PH_0;
          st_d.tick_left    = '0;
        end
      end
    end else if (busy) begin
      rej = 1'b1;
    end else begin
      st_d.command_held = op;
      st_d.phase        = PH_0;
      st_d.bit_index    = '0;
      case (op)
        OP_START: begin
          st_d.sda_dir   = 1'b1;
          st_d.scl_level = 1'b1;
          st_d.sda_level = 1'b1;
          st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_4US);
        end
        OP_STOP: begin
          st_d.sda_dir   = 1'b1;
          st_d.scl_level = 1'b0;
          st_d.sda_level = 1'b0;
          st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_4US);
        end
        OP_WRITE: begin
          st_d.sda_dir   = 1'b1;
          st_d.scl_level = 1'b0;
          st_d.sda_level = item_i.tx_byte[7];
          st_d.shift_reg = {item_i.tx_byte[6:0], 1'b0};
          st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_2US);
        end
        OP_READ: begin
          st_d.sda_dir   = 1'b0;
          st_d.sda_level = 1'b1;
          st_d.scl_level = 1'b0;
          st_d.shift_reg = '0;
          st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_2US);
        end
        OP_ACK, OP_NACK: begin
          st_d.sda_dir   = 1'b1;
          st_d.scl_level = 1'b0;
          st_d.sda_level = (op == OP_NACK);
          st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_2US);
        end
        default: begin
          st_d.sda_dir   = 1'b0;
          st_d.sda_level = 1'b1;
          st_d.ack_ticks = '0;
          st_d.ack_flag  = 1'b0;
          st_d.tick_left = phase_ticks(cfg_i.ticks_per_us, SH_1US);
        end
      endcase
    end
  end

  always_comb begin
    res_o.scl         = st_d.scl_level;
    res_o.sda_out     = st_d.sda_level;
    res_o.sda_drive   = st_d.sda_dir;
    res_o.busy_res    = (st_d.command_held != OP_TICK);
    res_o.done_res    = done;
    res_o.rx_byte     = st_d.rx_reg;
    res_o.ack_missing = st_d.ack_flag;
    res_o.rejected    = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.command_held <= OP_TICK;
      st_q.phase        <= PH_0;
      st_q.bit_index    <= '0;
      st_q.shift_reg    <= '0;
      st_q.tick_left    <= '0;
      st_q.ack_ticks    <= '0;
      st_q.scl_level    <= 1'b1;
      st_q.sda_level    <= 1'b1;
      st_q.sda_dir      <= 1'b1;
      st_q.rx_reg       <= '0;
      st_q.ack_flag     <= 1'b0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  `ASSERT_PROP(a_idle_clean, clk_i, rst_ni, !busy |-> (st_q.tick_left == '0 && st_q.phase == PH_0), "idle engine holds a running timer or phase")
  `ASSERT_NEVER(a_done_rej, clk_i, rst_ni, done && rej, "one word both finished and rejected a command")
  `ASSERT_PROP(a_start_busy, clk_i, rst_ni, (step_i && !busy && op != OP_TICK) |=> busy, "command taken while idle did not make the engine busy")
  `ASSERT_PROP(a_sample_released, clk_i, rst_ni, (busy && st_q.phase == PH_2 && st_q.command_held == OP_WAITACK) |-> !st_q.sda_dir, "ack sampled while SDA still driven")

endmodule

// ===== design/i2c_master_bit_engine_unit.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine
// Command- and tick-driven I2C master producing SCL/SDA levels per word.
// ----------------------------------------------------------------------------
// Every input word is either a tick carrying the sampled SDA level or a
// command (start, stop, write byte, read byte, ack, nack, wait ack), and each
// one yields exactly one result word showing SCL, SDA, the SDA drive enable
// and the status flags after that word. The engine takes one word per clock
// while the result register is free or being read: a word is held in the
// input register, is stepped by the core in a single pass and its result is
// loaded into the result register. The input register and the result
// register give two words of buffering, so a new word is still taken while a
// finished result waits for the consumer. Bus phase lengths are counted in
// ticks (ticks_per_us times 4, 2 or 1, at least one tick). Write the
// registers only while the engine is idle and the pipeline is empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit import i2cmbe_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2cmbe_in_if.sink     in_i,
  i2cmbe_cfg_if.sink    cfg_i,
  i2cmbe_out_if.source  out_o
);

  cfg_t     cfg;
  in_item_t item;
  logic     item_valid;
  logic     step;
  res_t     res_d, res_q;
  logic     res_valid_q;

  // Step the core when a word waits and the result slot is free or emptying
  assign step = item_valid && (!res_valid_q || out_o.ready);

  i2cmbe_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  i2cmbe_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (step),
    .valid_o (item_valid),
    .item_o  (item)
  );

  i2cmbe_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item),
    .step_i (step),
    .res_o  (res_d)
  );

  // Result register: load on a step, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.scl         = res_q.scl;
  assign out_o.sda_out     = res_q.sda_out;
  assign out_o.sda_drive   = res_q.sda_drive;
  assign out_o.busy_res    = res_q.busy_res;
  assign out_o.done_res    = res_q.done_res;
  assign out_o.rx_byte     = res_q.rx_byte;
  assign out_o.ack_missing = res_q.ack_missing;
  assign out_o.rejected    = res_q.rejected;

endmodule

// ===== dv/i2cmbe_level_checker.sv =====
// ----------------------------------------------------------------------------
// I2C bit engine level checker
// Watches the input, register and result channels of the bit engine, steps
// its own model of the engine for every accepted input word and compares each
// result word with the oldest predicted bus levels and flags.
// ----------------------------------------------------------------------------
module i2cmbe_level_checker import i2cmbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cmbe_in_if        in_mon,
  i2cmbe_cfg_if       cfg_mon,
  i2cmbe_out_if       out_mon,
  input  logic        closing_i,
  output logic        busy_o,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);

  // timing registers as last written
  logic [7:0]        tpu;
  logic [7:0]        ack_limit;

  // engine model
  op_e               held_op;
  phase_e            seg;
  logic [3:0]        bit_cnt;
  logic [7:0]        shifter;
  logic [TICK_W-1:0] ticks_left;
  logic [7:0]        ack_cnt;
  logic              scl_q;
  logic              sda_q;
  logic              drive_q;
  logic [7:0]        rx_q;
  logic              ack_miss_q;

  res_t              levels_due[$];
  int unsigned       fail_cnt = 0;
  int unsigned       words_seen = 0;
  bit                closed = 1'b0;

  assign mismatches_o = fail_cnt;

  task automatic report(string msg);
    fail_cnt++;
    $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report($sformatf("result word %0d: %s is %0h, expected %0h", words_seen, name, got, want));
    end
  endtask

  // Ticks in a phase of the given microseconds, at least one
  function automatic logic [TICK_W-1:0] span(int unsigned us);
    int unsigned d;
    d = us * tpu;
    if (d == 0) begin
      d = 1;
    end
    return TICK_W'(d);
  endfunction

  function automatic void enter(phase_e p, int unsigned us);
    seg        = p;
    ticks_left = span(us);
  endfunction

  function automatic void shift_out();
    sda_q   = shifter[7];
    shifter = {shifter[6:0], 1'b0};
  endfunction

  function automatic void wrap_up();
    held_op    = OP_TICK;
    seg        = PH_0;
    ticks_left = '0;
  endfunction

  // Set the bus up for a command taken while idle
  function automatic void launch(op_e op, logic [7:0] tx);
    held_op = op;
    seg     = PH_0;
    bit_cnt = '0;
    case (op)
      OP_START: begin
        drive_q = 1'b1; scl_q = 1'b1; sda_q = 1'b1; ticks_left = span(4);
      end
      OP_STOP: begin
        drive_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0; ticks_left = span(4);
      end
      OP_WRITE: begin
        drive_q = 1'b1; scl_q = 1'b0; shifter = tx; shift_out(); ticks_left = span(2);
      end
      OP_READ: begin
        drive_q = 1'b0; sda_q = 1'b1; scl_q = 1'b0; shifter = '0; ticks_left = span(2);
      end
      OP_ACK, OP_NACK: begin
        drive_q = 1'b1; scl_q = 1'b0; sda_q = (op == OP_NACK); ticks_left = span(2);
      end
      default: begin
        drive_q = 1'b0; sda_q = 1'b1; ack_cnt = '0; ack_miss_q = 1'b0; ticks_left = span(1);
      end
    endcase
  endfunction

  // One tick while busy; returns 1 when the command completes
  function automatic bit tick_engine(logic sda);
    if (held_op == OP_WAITACK && seg == PH_2) begin
      if (!sda) begin
        scl_q = 1'b0; ack_miss_q = 1'b0; wrap_up();
        return 1'b1;
      end
      ack_cnt = ack_cnt + 8'd1;
      if (ack_cnt >= ack_limit) begin
        scl_q = 1'b0; ack_miss_q = 1'b1; wrap_up();
        return 1'b1;
      end
      return 1'b0;
    end
    if (ticks_left > 1) begin
      ticks_left--;
      return 1'b0;
    end
    case (held_op)
      OP_START: begin
        if (seg == PH_0) begin
          sda_q = 1'b0; enter(PH_1, 4);
          return 1'b0;
        end
        scl_q = 1'b0; wrap_up();
        return 1'b1;
      end
      OP_STOP: begin
        if (seg == PH_0) begin
          scl_q = 1'b1; sda_q = 1'b1; enter(PH_1, 4);
          return 1'b0;
        end
        wrap_up();
        return 1'b1;
      end
      OP_WRITE: begin
        if (seg == PH_0) begin
          scl_q = 1'b1; enter(PH_1, 2);
          return 1'b0;
        end
        if (seg == PH_1) begin
          scl_q = 1'b0; enter(PH_2, 2);
          return 1'b0;
        end
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= BITS_PER_BYTE) begin
          wrap_up();
          return 1'b1;
        end
        shift_out(); enter(PH_0, 2);
        return 1'b0;
      end
      OP_READ: begin
        if (seg == PH_0) begin
          scl_q = 1'b1; enter(PH_1, 2);
          return 1'b0;
        end
        // sample at the end of the high phase
        shifter = {shifter[6:0], sda};
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= BITS_PER_BYTE) begin
          rx_q = shifter; wrap_up();
          return 1'b1;
        end
        scl_q = 1'b0; enter(PH_0, 2);
        return 1'b0;
      end
      OP_ACK, OP_NACK: begin
        if (seg == PH_0) begin
          scl_q = 1'b1; enter(PH_1, 2);
          return 1'b0;
        end
        scl_q = 1'b0; wrap_up();
        return 1'b1;
      end
      OP_WAITACK: begin
        if (seg == PH_0) begin
          scl_q = 1'b1; enter(PH_1, 1);
          return 1'b0;
        end
        seg = PH_2; ticks_left = '0;
        return 1'b0;
      end
      default: begin
        wrap_up();
        return 1'b1;
      end
    endcase
  endfunction

  function automatic res_t step_engine(in_item_t w);
    res_t r;
    bit   fin;
    bit   rej;
    fin = 1'b0;
    rej = 1'b0;
    if (op_e'(w.operation) == OP_TICK) begin
      if (held_op != OP_TICK) begin
        fin = tick_engine(w.sda_in);
      end
    end else if (held_op != OP_TICK) begin
      rej = 1'b1;
    end else begin
      launch(op_e'(w.operation), w.tx_byte);
    end
    r.scl         = scl_q;
    r.sda_out     = sda_q;
    r.sda_drive   = drive_q;
    r.busy_res    = (held_op != OP_TICK);
    r.done_res    = fin;
    r.rx_byte     = rx_q;
    r.ack_missing = ack_miss_q;
    r.rejected    = rej;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    in_item_t w;
    res_t     want;
    if (!rst_ni) begin
      tpu        = TPU_RESET;
      ack_limit  = ACK_TIMEOUT_RESET;
      held_op    = OP_TICK;
      seg        = PH_0;
      bit_cnt    = '0;
      shifter    = '0;
      ticks_left = '0;
      ack_cnt    = '0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      drive_q    = 1'b1;
      rx_q       = '0;
      ack_miss_q = 1'b0;
      levels_due.delete();
      busy_o    <= 1'b0;
      pending_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_reg_e'(cfg_mon.index) == REG_TICKS_PER_US) begin
          tpu = cfg_mon.data;
        end else begin
          ack_limit = cfg_mon.data;
        end
      end
      // push before pop
      if (in_mon.valid && in_mon.ready) begin
        w.operation = in_mon.operation;
        w.tx_byte   = in_mon.tx_byte;
        w.sda_in    = in_mon.sda_in;
        levels_due.push_back(step_engine(w));
      end
      if (out_mon.valid && out_mon.ready) begin
        words_seen++;
        if (levels_due.size() == 0) begin
          report($sformatf("result word %0d arrived with nothing expected", words_seen));
        end else begin
          want = levels_due.pop_front();
          check_field("scl", out_mon.scl, want.scl);
          check_field("sda_out", out_mon.sda_out, want.sda_out);
          check_field("sda_drive", out_mon.sda_drive, want.sda_drive);
          check_field("busy_res", out_mon.busy_res, want.busy_res);
          check_field("done_res", out_mon.done_res, want.done_res);
          check_field("rx_byte", out_mon.rx_byte, want.rx_byte);
          check_field("ack_missing", out_mon.ack_missing, want.ack_missing);
          check_field("rejected", out_mon.rejected, want.rejected);
        end
      end
      if (closing_i && !closed) begin
        closed = 1'b1;
        if (levels_due.size() != 0) begin
          report($sformatf("%0d result words never arrived", levels_due.size()));
        end
      end
      busy_o    <= (held_op != OP_TICK);
      pending_o <= levels_due.size();
    end
  end

endmodule

// ===== dv/tb_i2c_master_bit_engine_unit.sv =====
// ----------------------------------------------------------------------------
// I2C bit engine testbench
// Drives command and tick words into the bit engine under several timing
// settings, with random gaps and result stalls, and leaves all checking of
// bus levels and flags to the level checker beside the engine.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine_unit;
  import i2cmbe_pkg::*;

  // long receiver hold-off that backs the engine up into its input
  localparam int unsigned HOLD_CYCLES  = 48;
  // random words per timing setting
  localparam int unsigned PHASE_WORDS  = 100;
  // low-SDA odds for wait ack: acked at once, soon, late, never
  localparam int unsigned ACK_ODDS [4] = '{1, 3, 12, 0};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        closing = 1'b0;
  logic        burst = 1'b0;
  logic        hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  bit          meddle = 1'b0;
  logic        busy;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned words_sent = 0;

  i2cmbe_in_if  in_if ();
  i2cmbe_out_if out_if ();
  i2cmbe_cfg_if cfg_if ();

  i2c_master_bit_engine_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  i2cmbe_level_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .cfg_mon      (cfg_if),
    .out_mon      (out_if),
    .closing_i    (closing),
    .busy_o       (busy),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Give up on a hung run; the slowest correct run ends far sooner
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: stall a random number of cycles before each word, except in
  // burst stretches, and once hold off for a long stretch so the engine fills.
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = burst ? 0 : $urandom_range(0, 11);
        if (stall != 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_if.ready <= 1'b1;
        do @(posedge clk_i); while (!out_if.valid);
      end
    end
  end

  // Offer one word after a random gap and hold it until taken. Lower valid
  // only when a gap follows, so back-to-back words keep it high.
  task automatic send_word(op_e op, logic [7:0] tx, logic sda);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.tx_byte   <= tx;
    in_if.sda_in    <= sda;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
  endtask

  // SDA low with odds one in low_odds; zero odds keeps SDA high
  function automatic logic draw_sda(int unsigned low_odds);
    if (low_odds == 0) begin
      return 1'b1;
    end
    return ($urandom_range(1, low_odds) == 1) ? 1'b0 : 1'b1;
  endfunction

  // Issue a command, then tick until the engine reports idle. The busy flag
  // trails by one word, which at worst costs one spare tick while idle.
  task automatic run_cmd(op_e op, logic [7:0] tx, int unsigned low_odds);
    send_word(op, tx, 1'($urandom_range(0, 1)));
    do begin
      if (meddle && $urandom_range(0, 24) == 0) begin
        // command while busy: expect it flagged and dropped
        send_word(op_e'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else begin
        send_word(OP_TICK, 8'($urandom_range(0, 255)), draw_sda(low_odds));
      end
    end while (busy);
  endtask

  // Drop valid, let every result come back, tick any running command to its
  // end with SDA low, and drain again: the engine is then idle and empty.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    if (busy) begin
      while (busy) send_word(OP_TICK, 8'($urandom_range(0, 255)), 1'b0);
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while (pending != 0) @(posedge clk_i);
    end
  endtask

  // Write both timing registers back to back
  task automatic set_timing(logic [7:0] tpu, logic [7:0] limit);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_TICKS_PER_US;
    cfg_if.data  <= tpu;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.index <= REG_ACK_TIMEOUT;
    cfg_if.data  <= limit;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // A well-formed transfer: start, address, ack, then a run of writes or of
  // reads closed by a nack, then stop; sometimes cut short before the stop.
  task automatic bus_transfer();
    int unsigned n;
    n = $urandom_range(1, 3);
    run_cmd(OP_START, 8'($urandom_range(0, 255)), 2);
    run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 2);
    run_cmd(OP_WAITACK, 8'($urandom_range(0, 255)), ACK_ODDS[$urandom_range(0, 3)]);
    if ($urandom_range(0, 1) == 0) begin
      repeat (n) begin
        run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 2);
        run_cmd(OP_WAITACK, 8'($urandom_range(0, 255)), ACK_ODDS[$urandom_range(0, 3)]);
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        run_cmd(OP_READ, 8'($urandom_range(0, 255)), 2);
        run_cmd((i == n - 1) ? OP_NACK : OP_ACK, 8'($urandom_range(0, 255)), 2);
      end
    end
    if ($urandom_range(0, 7) != 0) begin
      run_cmd(OP_STOP, 8'($urandom_range(0, 255)), 2);
    end
  endtask

  initial begin
    int unsigned goal;
    logic        b;

    // hold every input at a known value from the first instant
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.operation  <= OP_TICK;
    in_if.tx_byte    <= 8'h00;
    in_if.sda_in     <= 1'b1;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= REG_TICKS_PER_US;
    cfg_if.data      <= 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset timing: one start and a quick ack at eight ticks per microsecond
    run_cmd(OP_START, 8'h00, 2);
    run_cmd(OP_WAITACK, 8'hFF, 1);
    settle();

    // Directed part at one tick per microsecond and a short ack timeout
    set_timing(8'd1, 8'd3);
    send_word(OP_TICK, 8'hFF, 1'b1);                // tick while idle: no change
    send_word(OP_START, 8'hFF, 1'b0);
    run_cmd(OP_STOP, 8'h00, 2);                     // stop while busy: rejected
    run_cmd(OP_WRITE, 8'hFF, 2);
    run_cmd(OP_WAITACK, 8'h00, 1);                  // ack on the first sample
    run_cmd(OP_WRITE, 8'h00, 2);
    run_cmd(OP_WAITACK, 8'hFF, 0);                  // no ack: times out
    run_cmd(OP_READ, 8'h00, 0);                     // all ones
    run_cmd(OP_ACK, 8'hFF, 2);
    run_cmd(OP_READ, 8'hFF, 1);                     // all zeros
    run_cmd(OP_NACK, 8'h00, 2);
    run_cmd(OP_WRITE, 8'hA5, 2);
    run_cmd(OP_WAITACK, 8'h5A, 3);
    run_cmd(OP_STOP, 8'hFF, 2);
    settle();

    // Zero ticks per microsecond: every phase lasts one tick; timeout of one
    set_timing(8'd0, 8'd1);
    run_cmd(OP_START, 8'h00, 2);
    run_cmd(OP_WRITE, 8'h5A, 2);
    run_cmd(OP_WAITACK, 8'h00, 0);
    run_cmd(OP_READ, 8'h00, 2);
    run_cmd(OP_NACK, 8'h00, 2);
    run_cmd(OP_STOP, 8'h00, 2);
    settle();

    // Random part: short timings so bytes complete, mostly proper transfers
    // with commands dropped in while busy, plus some loose words
    meddle = 1'b1;
    for (int p = 0; p < 3; p++) begin
      set_timing(8'(p % 3 + 1),
                 (p == 0) ? 8'd255 : (p == 1) ? 8'd1 : 8'($urandom_range(2, 254)));
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) begin
        b = ($urandom_range(0, 3) == 0);
        if (p == 2 && !hold_req) begin
          // back the engine up: no gaps while the result side holds off
          b = 1'b1;
          hold_req <= 1'b1;
        end
        burst <= b;
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_word(op_e'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
          end
        end else begin
          bus_transfer();
        end
      end
      settle();
    end
    meddle = 1'b0;

    // Top timing settings: a wait ack with 255-tick phases, acked on the
    // first sample
    burst <= 1'b1;
    set_timing(8'd255, 8'd255);
    run_cmd(OP_WAITACK, 8'hFF, 1);
    burst <= 1'b0;
    settle();

    // Let any stray word show, then flag leftovers and give the verdict
    repeat (6) @(posedge clk_i);
    closing <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/i2cmbe_pkg.sv
design/i2cmbe_if.sv
design/i2cmbe_cfg.sv
design/i2cmbe_in_stage.sv
design/i2cmbe_core.sv
design/i2c_master_bit_engine_unit.sv
dv/i2cmbe_level_checker.sv
dv/tb_i2c_master_bit_engine_unit.sv
